[rtl/mexp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes and the request type of the reducer.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Operand width used for all arithmetic (8 to 32).
  localparam int WIDTH = 32;

  // Width of the external data fields.
  localparam int FIELD_W = 32;

  // Counter width for the bit-serial reducer, able to hold WIDTH itself.
  localparam int CNT_W = $clog2(WIDTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

  // Request into the shift-subtract reducer: reduce {hi, lo} by the modulus.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] hi;
    logic [WIDTH-1:0] lo;
  } mexp_red_req_t;

endpackage

[rtl/modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// Each modular product passes the S_MUL multiply, the S_RED launch, WIDTH shift-subtract
// steps in the reducer and a writeback from S_WAIT; the base reduction skips the multiply.
// An item adds one check per exponent bit, one product per set bit and one squaring per bit
// below the top set bit. Reset loads exponent 1, modulus 1, empty output.
// One item at a time: the next is accepted once the result is registered and the unit is
// back in idle, and a held result stalls it further.
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Right-to-left square-and-multiply over a shared multiplier and a bit-serial
// modular reducer, driven by a small sequencer.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FIELD_W-1:0]   in_base_value,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   out_power_result
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_RED   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Which operation the reducer result belongs to.
  localparam logic [1:0] OP_BASE = 2'd0;
  localparam logic [1:0] OP_ACC  = 2'd1;
  localparam logic [1:0] OP_SQR  = 2'd2;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [FIELD_W-1:0] exp_cfg_r, exp_cfg_nxt;
  logic [FIELD_W-1:0] mod_cfg_r, mod_cfg_nxt;
  logic [WIDTH-1:0]   exp_r, exp_nxt;
  logic [WIDTH-1:0]   base_r, base_nxt;
  logic [WIDTH-1:0]   acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r, out_data_nxt;

  logic [WIDTH-1:0]   mul_a;
  logic [2*WIDTH-1:0] prod;
  mexp_red_req_t      red_req;
  logic               red_done;
  logic [WIDTH-1:0]   red_result;
  logic               in_accept;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Shared multiplier: accumulator times base, or base squared.
  assign mul_a = (op_r == OP_ACC) ? acc_r : base_r;

  mexp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (base_r),
    .prod (prod)
  );

  // Reducer launch: the raw base has a zero upper half, products use both halves.
  always_comb begin
    red_req.start = (state_r == S_RED);
    if (op_r == OP_BASE) begin
      red_req.hi = '0;
      red_req.lo = base_r;
    end else begin
      red_req.hi = prod[2*WIDTH-1:WIDTH];
      red_req.lo = prod[WIDTH-1:0];
    end
  end

  mexp_red u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (red_req),
    .modulus (mod_cfg_r[WIDTH-1:0]),
    .done    (red_done),
    .result  (red_result)
  );

  // Sequencer and configuration writes.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    exp_cfg_nxt   = exp_cfg_r;
    mod_cfg_nxt   = mod_cfg_r;
    exp_nxt       = exp_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_EXPONENT) begin
        exp_cfg_nxt = cfg_data;
      end else if (cfg_index == REG_MODULUS) begin
        mod_cfg_nxt = cfg_data;
      end
    end

    // The consumer took the held result transaction.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          base_nxt  = in_base_value[WIDTH-1:0];
          exp_nxt   = exp_cfg_r[WIDTH-1:0];
          acc_nxt   = WIDTH'(1);
          op_nxt    = OP_BASE;
          state_nxt = S_RED;
        end
      end
      S_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = S_DONE;
        end else if (exp_r[0]) begin
          op_nxt    = OP_ACC;
          state_nxt = S_MUL;
        end else begin
          op_nxt    = OP_SQR;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (red_done) begin
          unique case (op_r)
            OP_BASE: begin
              base_nxt  = red_result;
              state_nxt = S_CHECK;
            end
            OP_ACC: begin
              acc_nxt = red_result;
              // No squaring is needed after the top exponent bit.
              if (exp_r[WIDTH-1:1] == '0) begin
                state_nxt = S_DONE;
              end else begin
                op_nxt    = OP_SQR;
                state_nxt = S_MUL;
              end
            end
            OP_SQR: begin
              base_nxt  = red_result;
              exp_nxt   = exp_r >> 1;
              state_nxt = S_CHECK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = FIELD_W'(acc_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_BASE;
      exp_cfg_r   <= FIELD_W'(1);
      mod_cfg_r   <= FIELD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      exp_cfg_r   <= exp_cfg_nxt;
      mod_cfg_r   <= mod_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    exp_r      <= exp_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

endmodule

[rtl/mexp_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registered operand multiplier
// Multiplies two WIDTH-bit operands and registers the full double-width product.
// ----------------------------------------------------------------------------
module mexp_mul
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic [WIDTH-1:0]     op_a,
  input  logic [WIDTH-1:0]     op_b,
  output logic [2*WIDTH-1:0]   prod
);

  logic [2*WIDTH-1:0] prod_r;

  // The product is payload only; the sequencer knows when it is valid.
  always_ff @(posedge clk) begin
    prod_r <= (2*WIDTH)'(op_a) * (2*WIDTH)'(op_b);
  end

  assign prod = prod_r;

endmodule

[rtl/mexp_red.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-subtract modular reducer
// Reduces a double-width value whose upper half is already below the modulus,
// one bit per cycle. A modulus of zero keeps the low WIDTH bits.
// ----------------------------------------------------------------------------
module mexp_red
  import mexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_red_req_t    req,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic [WIDTH-1:0] lo_r, lo_nxt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // One restoring division step: bring in the next dividend bit and subtract.
  assign shifted = {rem_r[WIDTH-1:0], lo_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, modulus};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    if (req.start) begin
      if (modulus == '0) begin
        // Modulus zero means plain truncation to WIDTH bits.
        rem_nxt  = {1'b0, req.lo};
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = {1'b0, req.hi};
        lo_nxt   = req.lo;
        cnt_nxt  = CNT_W'(WIDTH);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = (shifted >= {1'b0, modulus}) ? diff : shifted;
      lo_nxt  = {lo_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
  end

  assign done   = done_r;
  assign result = rem_r[WIDTH-1:0];

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Sends message values through the input channel under several exponent and
// modulus settings. Each returned power is checked in order against a listed
// power or a square-and-multiply predictor. Random gaps appear on both channels, and one
// long output hold-off backs the unit up.
// ----------------------------------------------------------------------------
module testbench
  import mexp_pkg::*;
;

  localparam int PROD_W          = 2 * WIDTH;
  localparam int NUM_DIRECTED    = 18;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int PRESSURE_PHASE  = 0;
  localparam int CALM_PHASE      = 3;
  localparam int HOLD_CYCLES     = 4000;
  localparam int IDLE_PERCENT    = 22;

  // Indexes past the end of the register list; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // One directed row: settings, message value and, where obvious, the power.
  typedef struct packed {
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] base;
    logic               poke_spare;
    logic               typed;
    logic [FIELD_W-1:0] power;
  } power_vector_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FIELD_W-1:0]   in_base_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_power_result;

  // Register copies and test bookkeeping.
  logic [FIELD_W-1:0] cur_exponent;
  logic [FIELD_W-1:0] cur_modulus;
  logic [FIELD_W-1:0] pending_powers[$];
  logic               calm = 1'b0;
  logic               hold_go = 1'b0;
  logic               hold_done = 1'b0;
  int unsigned        hold_left = 0;
  int                 mismatch_count = 0;
  int                 results_seen = 0;
  int                 settings_used = 0;

  power_vector_t directed_vectors [NUM_DIRECTED] = '{
    '{32'd1, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0},
    '{32'd1, 32'd1, 32'd0, 1'b0, 1'b1, 32'd0},
    '{32'd0, 32'd1, 32'd123, 1'b0, 1'b1, 32'd1},
    '{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, 32'd1},
    '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0},
    '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b1, 32'hFFFF_FFFE},
    '{32'd2, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'd0, 32'd3, 1'b0, 1'b0, 32'd0},
    '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b0, 1'b0, 32'd0},
    '{32'd17, 32'd3233, 32'd65, 1'b0, 1'b1, 32'd2790},
    '{32'd2753, 32'd3233, 32'd2790, 1'b0, 1'b1, 32'd65},
    '{32'd2753, 32'd3233, 32'd5, 1'b1, 1'b0, 32'd0},
    '{32'h8000_0000, 32'hFFFF_FFFB, 32'h1234_5678, 1'b0, 1'b0, 32'd0},
    '{32'd3, 32'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd1},
    '{32'hFFFF_FFFF, 32'd1, 32'd7, 1'b0, 1'b1, 32'd0},
    '{32'd5, 32'h8000_0000, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0}
  };

  modular_exponentiation_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reduction by the modulus; a zero modulus stands for 2^WIDTH.
  function automatic logic [WIDTH-1:0] reduce_mod(input logic [PROD_W-1:0] x,
                                                  input logic [WIDTH-1:0] m);
    if (m == '0) begin
      return x[WIDTH-1:0];
    end
    return WIDTH'(x % PROD_W'(m));
  endfunction

  // Right-to-left square-and-multiply on the low WIDTH bits of each operand.
  function automatic logic [FIELD_W-1:0] modpow(input logic [FIELD_W-1:0] base_in,
                                                input logic [FIELD_W-1:0] exp_in,
                                                input logic [FIELD_W-1:0] mod_in);
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] acc;
    m = mod_in[WIDTH-1:0];
    e = exp_in[WIDTH-1:0];
    b = reduce_mod(PROD_W'(base_in[WIDTH-1:0]), m);
    acc = WIDTH'(1);
    while (e != '0) begin
      if (e[0]) begin
        acc = reduce_mod(PROD_W'(acc) * PROD_W'(b), m);
      end
      b = reduce_mod(PROD_W'(b) * PROD_W'(b), m);
      e = e >> 1;
    end
    return FIELD_W'(acc);
  endfunction

  // Result side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time,
                 out_power_result);
        mismatch_count <= mismatch_count + 1;
      end else if (pending_powers[0] !== out_power_result) begin
        $display("%0t: power_result mismatch: expected %h, actual %h", $time,
                 pending_powers[0], out_power_result);
        mismatch_count <= mismatch_count + 1;
        void'(pending_powers.pop_front());
      end else begin
        void'(pending_powers.pop_front());
      end
    end
    // Long hold-off once, otherwise random stalls outside the calm stretch.
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Offer one message value, with random gaps, and record its power.
  task automatic push_base(input logic [FIELD_W-1:0] value, input logic typed,
                           input logic [FIELD_W-1:0] typed_power);
    while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_value <= value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (typed) begin
      pending_powers = {pending_powers, typed_power};
    end else begin
      pending_powers = {pending_powers, modpow(value, cur_exponent, cur_modulus)};
    end
  endtask

  // Stop offering and wait until every outstanding power has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // One register write transaction, tracked in the local copies.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_EXPONENT: cur_exponent = data;
      REG_MODULUS:  cur_modulus = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Exponent for a random phase; most are short so that items stay quick.
  function automatic logic [FIELD_W-1:0] pick_exponent(input int phase);
    int unsigned len;
    logic [FIELD_W-1:0] mask;
    if (phase == PRESSURE_PHASE) begin
      return 32'd3;
    end
    if (phase == 5) begin
      return $urandom() | 32'h8000_0000;
    end
    if (phase == 8) begin
      return 32'hFFFF_FFFF;
    end
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      default: begin
        len = $urandom_range(2, 12);
        mask = (32'd1 << len) - 32'd1;
        return ($urandom() & mask) | (32'd1 << (len - 1));
      end
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_modulus;
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom_range(2, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_base;
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return cur_modulus;
      3: return cur_modulus - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    power_vector_t row;
    int random_items;
    random_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cur_exponent = 32'd1;
    cur_modulus = 32'd1;
    settings_used = 1;

    // Directed rows; registers change only when the unit is idle.
    foreach (directed_vectors[i]) begin
      row = directed_vectors[i];
      if (row.exponent != cur_exponent || row.modulus != cur_modulus
          || row.poke_spare) begin
        drain();
        settings_used++;
      end
      if (row.exponent != cur_exponent) begin
        write_reg(REG_EXPONENT, row.exponent);
      end
      if (row.modulus != cur_modulus) begin
        write_reg(REG_MODULUS, row.modulus);
      end
      if (row.poke_spare) begin
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
      end
      push_base(row.base, row.typed, row.power);
    end

    // Random phases, each under a fresh exponent and modulus.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      write_reg(REG_EXPONENT, pick_exponent(phase));
      write_reg(REG_MODULUS, pick_modulus());
      settings_used++;
      calm <= (phase == CALM_PHASE);
      hold_go <= (phase == PRESSURE_PHASE);
      @(posedge clk);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        push_base(pick_base(), 1'b0, '0);
        random_items++;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d directed and %0d random transactions under %0d register settings.",
             NUM_DIRECTED, random_items, settings_used);
    $display("Checked %0d results, including a %0d-cycle output hold-off.",
             results_seen, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("PASS modular_exponentiation_unit");
    end else begin
      $display("FAIL modular_exponentiation_unit");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("%0t: timeout with %0d results pending", $time, pending_powers.size());
    $display("FAIL modular_exponentiation_unit");
    $finish;
  end

endmodule
